FILE: hw/rtl/sha2he_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha2he_pkg
// Shared types and constants of the SHA-256 / SHA-224 hash engine: word and
// working-set types, round constants, initial values.
// ----------------------------------------------------------------------------
package sha2he_pkg;

   typedef logic [31:0] word_type;

   // Eight-word set a..h (or H0..H7), index 0 is a / H0
   typedef word_type [0:7] work_type;

   localparam int        BLOCK_WORDS = 16;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [5:0] PAD_LIMIT  = 6'd56;
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [6:0] BLOCK_BYTES = 7'd64;

   localparam logic [2:0] LAST_IDX_SHA256 = 3'd7;
   localparam logic [2:0] LAST_IDX_SHA224 = 3'd6;

   localparam logic MODE_SHA256 = 1'b0;
   localparam logic MODE_SHA224 = 1'b1;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam work_type IV_SHA256 = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam work_type IV_SHA224 = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   function automatic work_type init_value(input logic mode);
      return (mode == MODE_SHA224) ? IV_SHA224 : IV_SHA256;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sha2he_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha2he_round
// One SHA-256 compression round and one message schedule step, shared by
// all 64 rounds of every block.
// ----------------------------------------------------------------------------
module sha2he_round
   import sha2he_pkg::*;
(
   input  work_type wv,
   input  word_type round_k,
   input  word_type w0,
   input  word_type w1,
   input  word_type w9,
   input  word_type w14,
   output work_type wv_next,
   output word_type w_next
);

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   word_type big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

   always_comb begin
      big_s1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
      ch     = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
      t1     = wv[7] + big_s1 + ch + round_k + w0;
      big_s0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
      maj    = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
      t2     = big_s0 + maj;
      wv_next = '{t1 + t2, wv[0], wv[1], wv[2], wv[3] + t1, wv[4], wv[5], wv[6]};
      // extend the schedule window by one word
      sm0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      sm1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      w_next = sm1 + w9 + sm0 + w0;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sha2he_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha2he_outbuf
// Digest holding buffer: takes a whole digest at once and hands it out one
// word per transfer, most significant word first.
// ----------------------------------------------------------------------------
module sha2he_outbuf
   import sha2he_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  work_type   load_words,
   input  logic [2:0] load_last_idx,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output word_type   rsp_digest_word,
   output logic       rsp_digest_last
);

   work_type   words_ff, words_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] last_idx_ff, last_idx_in;
   logic       valid_ff, valid_in;

   always_comb begin
      words_in    = words_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      valid_in    = valid_ff;
      if (load) begin
         words_in    = load_words;
         idx_in      = '0;
         last_idx_in = load_last_idx;
         valid_in    = 1'b1;
      end else if (valid_ff && rsp_ready) begin
         if (idx_ff == last_idx_ff) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         last_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         last_idx_ff <= last_idx_in;
         valid_ff    <= valid_in;
      end
      words_ff <= words_in;
   end

   assign busy            = valid_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_digest_word = words_ff[idx_ff];
   assign rsp_digest_last = (idx_ff == last_idx_ff);

endmodule
`default_nettype wire

FILE: hw/rtl/sha256_sha224_hash_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_sha224_hash_engine_core
// Streaming SHA-256 / SHA-224 engine with a single shared round unit.
// ----------------------------------------------------------------------------
// Feed the message as big-endian 32-bit words, each with its count of valid
// bytes (counts above four act as four) and an end flag on the final word;
// an empty message is a single end word with a count of zero. A word that
// does not fill the 64-byte block is merged into the block buffer. The word
// that fills a block starts the compression: 64 rounds of the shared round
// unit (one round per cycle, the schedule window is the block buffer itself,
// shifted once a round) and then a final step that folds the working set
// into the chaining value; if the word spills past the block end, the
// remainder is stored afterwards in the ABSORB state. The end word adds a
// padding step, one compression (two when more than 55 bytes are held, with
// a step to set up the length-only block) and a step to hand the digest to
// the output buffer, once the previous digest has drained. No new word is
// taken while a block is being compressed. The digest (eight words for
// SHA-256, seven for SHA-224) drains from its own buffer, so the next message
// may start while it is still being taken. Writing digest_mode drops any
// message in progress and restarts from the new mode's initial value; write
// it only while idle.
// ----------------------------------------------------------------------------
module sha256_sha224_hash_engine_core
   import sha2he_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   state_type   cont_ff, cont_in;      // where to resume after a compression
   logic        mode_ff, mode_in;
   work_type    chain_ff, chain_in;
   work_type    wv_ff, wv_in;
   word_type    blk_ff [BLOCK_WORDS];
   word_type    blk_in [BLOCK_WORDS];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  rnd_ff, rnd_in;
   word_type    hold_word_ff, hold_word_in;
   logic [2:0]  hold_cnt_ff, hold_cnt_in;
   logic        hold_last_ff, hold_last_in;

   // Absorb path: bytes come from the port in IDLE, from the held remainder
   // in ABSORB.
   word_type    src_word;
   logic [2:0]  src_cnt;
   logic        last_now;
   logic [6:0]  room;
   logic [2:0]  take;
   logic [6:0]  fill_sum;
   logic        block_full;
   word_type    blk_merge [BLOCK_WORDS];
   word_type    blk_pad [BLOCK_WORDS];
   word_type    blk_len [BLOCK_WORDS];

   work_type    rnd_wv;
   word_type    rnd_w;

   logic        ob_load;
   logic        ob_busy;

   sha2he_round u_round (
      .wv      (wv_ff),
      .round_k (ROUND_K[rnd_ff]),
      .w0      (blk_ff[0]),
      .w1      (blk_ff[1]),
      .w9      (blk_ff[9]),
      .w14     (blk_ff[14]),
      .wv_next (rnd_wv),
      .w_next  (rnd_w)
   );

   sha2he_outbuf u_outbuf (
      .clock           (clock),
      .reset           (reset),
      .load            (ob_load),
      .load_words      (chain_ff),
      .load_last_idx   ((mode_ff == MODE_SHA224) ? LAST_IDX_SHA224 : LAST_IDX_SHA256),
      .busy            (ob_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_digest_last (rsp_digest_last)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      if (state_ff == ST_ABSORB) begin
         src_word = hold_word_ff;
         src_cnt  = hold_cnt_ff;
         last_now = hold_last_ff;
      end else begin
         src_word = req_data_word;
         src_cnt  = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
         last_now = req_message_end;
      end
      // take no more bytes than the block has room for
      room       = BLOCK_BYTES - {1'b0, fill_ff};
      take       = ({4'd0, src_cnt} > room) ? room[2:0] : src_cnt;
      fill_sum   = {1'b0, fill_ff} + {4'd0, take};
      block_full = (fill_sum == BLOCK_BYTES);
   end

   // Drop the accepted bytes into their byte lanes at the fill position.
   always_comb begin
      logic [5:0] off;
      for (int p = 0; p < 64; p++) begin
         off = 6'(p) - fill_ff;
         if (p % 4 == 0) begin
            blk_merge[p / 4] = blk_ff[p / 4];
         end
         if (off < {3'd0, take}) begin
            blk_merge[p / 4][8 * (3 - p % 4) +: 8] = 8'(src_word >> {~off[1:0], 3'b000});
         end
      end
   end

   // Padding: marker byte at the fill position, zeros after it, and the bit
   // length in the last two words when it fits in this block.
   always_comb begin
      for (int p = 0; p < 64; p++) begin
         if (p % 4 == 0) begin
            blk_pad[p / 4] = blk_ff[p / 4];
         end
         if (6'(p) == fill_ff) begin
            blk_pad[p / 4][8 * (3 - p % 4) +: 8] = PAD_BYTE;
         end else if (6'(p) > fill_ff) begin
            blk_pad[p / 4][8 * (3 - p % 4) +: 8] = 8'h00;
         end
      end
      if (fill_ff < PAD_LIMIT) begin
         blk_pad[14] = bits_ff[63:32];
         blk_pad[15] = bits_ff[31:0];
      end
   end

   // Extra length-only block when the marker left no room for the length.
   always_comb begin
      for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
         blk_len[i] = '0;
      end
      blk_len[14] = bits_ff[63:32];
      blk_len[15] = bits_ff[31:0];
   end

   always_comb begin
      state_in     = state_ff;
      cont_in      = cont_ff;
      mode_in      = mode_ff;
      chain_in     = chain_ff;
      wv_in        = wv_ff;
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      rnd_in       = rnd_ff;
      hold_word_in = hold_word_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_last_in = hold_last_ff;
      ob_load      = 1'b0;

      case (state_ff)
         ST_IDLE, ST_ABSORB: begin
            if (state_ff == ST_ABSORB || req_valid) begin
               if (state_ff == ST_IDLE) begin
                  bits_in      = bits_ff + {58'd0, src_cnt, 3'b000};
                  hold_last_in = req_message_end;
               end
               blk_in       = blk_merge;
               hold_word_in = src_word << {take, 3'b000};
               hold_cnt_in  = src_cnt - take;
               if (block_full) begin
                  // block complete: compress, then store any spill-over
                  fill_in  = '0;
                  wv_in    = chain_ff;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
                  if (src_cnt != take) begin
                     cont_in = ST_ABSORB;
                  end else if (last_now) begin
                     cont_in = ST_PAD;
                  end else begin
                     cont_in = ST_IDLE;
                  end
               end else begin
                  fill_in  = fill_sum[5:0];
                  state_in = last_now ? ST_PAD : ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            blk_in   = blk_pad;
            wv_in    = chain_ff;
            rnd_in   = '0;
            state_in = ST_ROUND;
            cont_in  = (fill_ff >= PAD_LIMIT) ? ST_LEN : ST_OUT;
            fill_in  = '0;
         end
         ST_LEN: begin
            blk_in   = blk_len;
            wv_in    = chain_ff;
            rnd_in   = '0;
            state_in = ST_ROUND;
            cont_in  = ST_OUT;
         end
         ST_ROUND: begin
            // advance one round and shift the schedule window
            wv_in = rnd_wv;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               blk_in[i] = blk_ff[i + 1];
            end
            blk_in[BLOCK_WORDS - 1] = rnd_w;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + wv_ff[i];
            end
            state_in = cont_ff;
         end
         ST_OUT: begin
            // hold until the previous digest has drained
            if (!ob_busy) begin
               ob_load  = 1'b1;
               chain_in = init_value(mode_ff);
               bits_in  = '0;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         mode_in  = csr_write_data;
         chain_in = init_value(csr_write_data);
         bits_in  = '0;
         fill_in  = '0;
         rnd_in   = '0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cont_ff      <= ST_IDLE;
         mode_ff      <= MODE_SHA256;
         chain_ff     <= IV_SHA256;
         fill_ff      <= '0;
         bits_ff      <= '0;
         rnd_ff       <= '0;
         hold_cnt_ff  <= '0;
         hold_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cont_ff      <= cont_in;
         mode_ff      <= mode_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         rnd_ff       <= rnd_in;
         hold_cnt_ff  <= hold_cnt_in;
         hold_last_ff <= hold_last_in;
      end
      wv_ff        <= wv_in;
      blk_ff       <= blk_in;
      hold_word_ff <= hold_word_in;
   end

endmodule
`default_nettype wire
